[design/slle_pkg.sv]
package slle_pkg;

	// table geometry
	localparam int SLOTS = 64;
	localparam int SW = $clog2(SLOTS);
	localparam int SUM_W = 32 + SW;

	// command codes
	localparam logic [3:0] CMD_INS_FRONT = 4'd0;
	localparam logic [3:0] CMD_INS_BACK  = 4'd1;
	localparam logic [3:0] CMD_INS_AFTER = 4'd2;
	localparam logic [3:0] CMD_DEL_FRONT = 4'd3;
	localparam logic [3:0] CMD_DEL_BACK  = 4'd4;
	localparam logic [3:0] CMD_DEL_AFTER = 4'd5;
	localparam logic [3:0] CMD_REVERSE   = 4'd6;
	localparam logic [3:0] CMD_SEARCH    = 4'd7;
	localparam logic [3:0] CMD_MIN       = 4'd8;
	localparam logic [3:0] CMD_AVG       = 4'd9;
	localparam logic [3:0] CMD_COUNT     = 4'd10;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef logic [SW-1:0] idx_t;

	// write request into the slot table
	typedef struct packed {
		logic en;
		idx_t addr;
		idx_t data;
	} link_wr_t;

	typedef struct packed {
		logic        en;
		idx_t        addr;
		logic [31:0] data;
	} val_wr_t;

endpackage

[design/slle_store.sv]
module slle_store (
	input  logic                clk,
	input  logic                arst_n,
	input  slle_pkg::idx_t      rd_addr,
	output slle_pkg::idx_t      link_rd,
	output logic signed [31:0]  val_rd,
	input  slle_pkg::link_wr_t  link_wr,
	input  slle_pkg::val_wr_t   val_wr,
	input  slle_pkg::idx_t      scan_addr,
	output logic                scan_nz
);

	slle_pkg::idx_t link_mem [slle_pkg::SLOTS];
	logic [31:0] val_mem [slle_pkg::SLOTS];
	// one bit per slot: link is non-nil, cleared at reset
	logic [slle_pkg::SLOTS-1:0] nz_q;
	slle_pkg::idx_t link_raw_q;
	logic nz_rd_q;
	logic [31:0] val_raw_q;

	// link and value memories
	always_ff @(posedge clk) begin
		if (link_wr.en) begin
			link_mem[link_wr.addr] <= link_wr.data;
		end
		if (val_wr.en) begin
			val_mem[val_wr.addr] <= val_wr.data;
		end
		link_raw_q <= link_mem[rd_addr];
		val_raw_q <= val_mem[rd_addr];
	end

	// non-nil flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
			nz_rd_q <= 1'b0;
		end else begin
			if (link_wr.en) begin
				nz_q[link_wr.addr] <= (link_wr.data != '0);
			end
			nz_rd_q <= nz_q[rd_addr];
		end
	end

	assign link_rd = nz_rd_q ? link_raw_q : '0;
	assign val_rd = val_raw_q;
	assign scan_nz = nz_q[scan_addr];

endmodule

[design/slle_div.sv]
module slle_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [slle_pkg::SUM_W-1:0]   dividend,
	input  slle_pkg::idx_t               divisor,
	output logic                         done,
	output logic [slle_pkg::SUM_W-1:0]   quotient
);

	localparam int CW = $clog2(slle_pkg::SUM_W + 1);

	logic [slle_pkg::SUM_W-1:0] q_q;
	logic [slle_pkg::SW:0] rem_q;
	slle_pkg::idx_t dvs_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [slle_pkg::SW:0] trial;
	logic [slle_pkg::SW:0] diff;
	logic fits;

	// one restoring step per cycle
	assign trial = {rem_q[slle_pkg::SW-1:0], q_q[slle_pkg::SUM_W-1]};
	assign fits = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(slle_pkg::SUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff : trial;
			q_q <= {q_q[slle_pkg::SUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = q_q;

endmodule

[design/static_linked_list_engine.sv]
// channel  | ports                              | handshake
// command  | command, value, position           | start & !busy
// result   | status, slot, data, count          | done, one cycle, no stall
//
// every command walks the list from head, through S_WALK then S_WDAT per element (link read port)
// inserts then scan the slot table one slot a cycle for the free slot
// average adds a serial divide of one quotient bit a cycle
// busy stays high until done pulses
// reset clears head, tail and the per-slot non-nil flags at once
module static_linked_list_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         command,
	input  logic signed [31:0] value,
	input  logic [5:0]         position,
	output logic               done,
	output logic [1:0]         status,
	output logic [5:0]         slot,
	output logic signed [31:0] data,
	output logic [5:0]         count
);

	typedef enum logic [3:0] {
		S_IDLE, S_WALK, S_WDAT, S_POST, S_FREE, S_INS, S_UPD, S_DEL1, S_DEL2, S_DIVW, S_FIN
	} state_t;

	state_t state_q;
	logic [3:0] cmd_q;
	logic signed [31:0] val_q;
	slle_pkg::idx_t pos_q, head_q, tail_q, cur_q, prev_q, prev2_q;
	slle_pkg::idx_t first_link_q, pos_link_q, q_link_q, found_slot_q, min_slot_q, free_q, n_q;
	logic pos_range_q, pos_seen_q, found_q;
	logic signed [31:0] min_q;
	logic signed [slle_pkg::SUM_W-1:0] sum_q;
	logic [1:0] status_q;
	slle_pkg::idx_t slot_q;
	logic [31:0] data_q;

	slle_pkg::idx_t link_rd, rd_addr;
	logic signed [31:0] val_rd;
	logic scan_nz;
	slle_pkg::link_wr_t link_wr;
	slle_pkg::val_wr_t val_wr;
	logic div_go, div_done;
	logic [slle_pkg::SUM_W-1:0] mag, quo;
	logic [31:0] quo_s;
	logic pos_ok;

	slle_store u_store (
		.clk(clk), .arst_n(arst_n), .rd_addr(rd_addr), .link_rd(link_rd), .val_rd(val_rd),
		.link_wr(link_wr), .val_wr(val_wr), .scan_addr(free_q), .scan_nz(scan_nz)
	);

	slle_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(mag), .divisor(n_q),
		.done(div_done), .quotient(quo)
	);

	assign pos_ok = pos_range_q && pos_q != '0 && pos_seen_q;
	assign mag = sum_q[slle_pkg::SUM_W-1] ? slle_pkg::SUM_W'(-sum_q) : slle_pkg::SUM_W'(sum_q);
	assign quo_s = sum_q[slle_pkg::SUM_W-1] ? 32'(-quo) : 32'(quo);
	assign rd_addr = (state_q == S_WALK) ? cur_q : '0;
	assign div_go = state_q == S_POST && cmd_q == slle_pkg::CMD_AVG && n_q != '0;

	// table write requests
	always_comb begin
		link_wr = '0;
		val_wr = '0;
		unique case (state_q)
			S_WDAT: begin
				if (cmd_q == slle_pkg::CMD_REVERSE) begin
					link_wr = '{en: 1'b1, addr: cur_q, data: prev_q};
				end
			end
			S_INS: begin
				val_wr = '{en: 1'b1, addr: free_q, data: val_q};
				link_wr.en = 1'b1;
				link_wr.addr = free_q;
				if (cmd_q == slle_pkg::CMD_INS_AFTER) begin
					link_wr.data = pos_link_q;
				end else if (cmd_q == slle_pkg::CMD_INS_FRONT && n_q != '0) begin
					link_wr.data = head_q;
				end
			end
			S_UPD: begin
				if (cmd_q == slle_pkg::CMD_INS_AFTER) begin
					link_wr = '{en: 1'b1, addr: pos_q, data: free_q};
				end else if (cmd_q == slle_pkg::CMD_INS_BACK && n_q != '0) begin
					link_wr = '{en: 1'b1, addr: tail_q, data: free_q};
				end
			end
			S_DEL1: begin
				link_wr.en = 1'b1;
				if (cmd_q == slle_pkg::CMD_DEL_FRONT) begin
					link_wr.addr = head_q;
				end else if (cmd_q == slle_pkg::CMD_DEL_BACK) begin
					link_wr.addr = (n_q == slle_pkg::idx_t'(1)) ? prev_q : prev2_q;
				end else begin
					link_wr.addr = pos_q;
					link_wr.data = q_link_q;
				end
			end
			S_DEL2: begin
				link_wr = '{en: 1'b1, addr: pos_link_q, data: '0};
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			cmd_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						val_q <= value;
						pos_q <= slle_pkg::idx_t'(position);
						pos_range_q <= 32'(position) < slle_pkg::SLOTS;
						cur_q <= head_q;
						n_q <= '0;
						prev_q <= '0;
						prev2_q <= '0;
						pos_seen_q <= 1'b0;
						found_q <= 1'b0;
						found_slot_q <= '0;
						sum_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					state_q <= (cur_q == '0) ? S_POST : S_WDAT;
				end
				S_WDAT: begin
					n_q <= n_q + 1'b1;
					prev2_q <= prev_q;
					prev_q <= cur_q;
					cur_q <= link_rd;
					if (n_q == '0) begin
						first_link_q <= link_rd;
					end
					if (cur_q == pos_q) begin
						pos_seen_q <= 1'b1;
						pos_link_q <= link_rd;
					end
					if (pos_seen_q && prev_q == pos_q) begin
						q_link_q <= link_rd;
					end
					if (!found_q && val_rd == val_q) begin
						found_q <= 1'b1;
						found_slot_q <= cur_q;
					end
					if (n_q == '0 || val_rd < min_q) begin
						min_q <= val_rd;
						min_slot_q <= cur_q;
					end
					sum_q <= sum_q + slle_pkg::SUM_W'(val_rd);
					state_q <= S_WALK;
				end
				S_POST: begin
					status_q <= slle_pkg::ST_OK;
					slot_q <= '0;
					data_q <= '0;
					state_q <= S_FIN;
					free_q <= slle_pkg::idx_t'(1);
					priority if (cmd_q <= slle_pkg::CMD_INS_AFTER) begin
						if (cmd_q == slle_pkg::CMD_INS_AFTER && !pos_ok) begin
							status_q <= slle_pkg::ST_BADPOS;
						end else if (32'(n_q) >= slle_pkg::SLOTS - 1) begin
							status_q <= slle_pkg::ST_FULL;
						end else begin
							state_q <= S_FREE;
						end
					end else if (cmd_q == slle_pkg::CMD_DEL_AFTER) begin
						if (!pos_ok || pos_link_q == '0) begin
							status_q <= slle_pkg::ST_BADPOS;
						end else begin
							slot_q <= pos_link_q;
							state_q <= S_DEL1;
						end
					end else if (cmd_q > slle_pkg::CMD_COUNT) begin
						status_q <= slle_pkg::ST_BADPOS;
					end else if (cmd_q == slle_pkg::CMD_COUNT) begin
						status_q <= slle_pkg::ST_OK;
					end else if (n_q == '0) begin
						status_q <= slle_pkg::ST_EMPTY;
					end else if (cmd_q == slle_pkg::CMD_DEL_FRONT) begin
						slot_q <= head_q;
						state_q <= S_DEL1;
					end else if (cmd_q == slle_pkg::CMD_DEL_BACK) begin
						slot_q <= prev_q;
						state_q <= S_DEL1;
					end else if (cmd_q == slle_pkg::CMD_REVERSE) begin
						tail_q <= head_q;
						head_q <= prev_q;
						slot_q <= prev_q;
					end else if (cmd_q == slle_pkg::CMD_SEARCH) begin
						status_q <= found_q ? slle_pkg::ST_OK : slle_pkg::ST_EMPTY;
						slot_q <= found_slot_q;
					end else if (cmd_q == slle_pkg::CMD_MIN) begin
						slot_q <= min_slot_q;
						data_q <= min_q;
					end else begin
						state_q <= S_DIVW;
					end
				end
				S_FREE: begin
					if (!scan_nz && free_q != tail_q) begin
						state_q <= S_INS;
					end else if (free_q == slle_pkg::idx_t'(slle_pkg::SLOTS - 1)) begin
						status_q <= slle_pkg::ST_FULL;
						state_q <= S_FIN;
					end else begin
						free_q <= free_q + 1'b1;
					end
				end
				S_INS: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					slot_q <= free_q;
					n_q <= n_q + 1'b1;
					if (cmd_q == slle_pkg::CMD_INS_AFTER) begin
						if (tail_q == pos_q) begin
							tail_q <= free_q;
						end
					end else if (n_q == '0) begin
						head_q <= free_q;
						tail_q <= free_q;
					end else if (cmd_q == slle_pkg::CMD_INS_FRONT) begin
						head_q <= free_q;
					end else begin
						tail_q <= free_q;
					end
					state_q <= S_FIN;
				end
				S_DEL1: begin
					n_q <= n_q - 1'b1;
					state_q <= S_FIN;
					if (cmd_q == slle_pkg::CMD_DEL_FRONT) begin
						head_q <= first_link_q;
						if (first_link_q == '0) begin
							tail_q <= '0;
						end
					end else if (cmd_q == slle_pkg::CMD_DEL_BACK) begin
						if (n_q == slle_pkg::idx_t'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							tail_q <= prev2_q;
						end
					end else begin
						if (tail_q == pos_link_q) begin
							tail_q <= pos_q;
						end
						state_q <= S_DEL2;
					end
				end
				S_DEL2: begin
					state_q <= S_FIN;
				end
				S_DIVW: begin
					if (div_done) begin
						data_q <= quo_s;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_FIN;
	assign status = status_q;
	assign slot = 6'(slot_q);
	assign data = data_q;
	assign count = 6'(n_q);

	// a request while idle is always taken
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request not taken");

	// head and tail are nil together
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == '0) == (tail_q == '0))
		else $error("head and tail disagree on empty list");

	// a successful insert names a real slot
	a_ins_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == slle_pkg::ST_OK && cmd_q <= slle_pkg::CMD_INS_AFTER |-> slot != '0)
		else $error("insert reported nil slot");

	// result only one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result held longer than one cycle");

endmodule

[verif/static_linked_list_engine_test.sv]
`timescale 1ns / 100ps

module static_linked_list_engine_test;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [3:0]         command;
	logic signed [31:0] value;
	logic [5:0]         position;
	logic               done;
	logic [1:0]         status;
	logic [5:0]         slot;
	logic signed [31:0] data;
	logic [5:0]         count;

	static_linked_list_engine i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .value(value), .position(position),
		.done(done), .status(status), .slot(slot), .data(data), .count(count)
	);

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [31:0] data;
		logic [5:0]  count;
	} reply_t;

	typedef struct {
		logic [3:0]  cmd;
		logic [31:0] val;
		logic [5:0]  pos;
		logic        has_exp;
		reply_t      exp;
	} row_t;

	// predictor copy of the list
	logic [5:0]  nxt [slle_pkg::SLOTS];
	logic [31:0] vals [slle_pkg::SLOTS];
	logic [5:0]  head, tail;
	logic [5:0]  order [slle_pkg::SLOTS];
	bit          seen [slle_pkg::SLOTS];

	reply_t pending_replies[$];
	int     errors = 0;
	bit     quiet = 0;

	// follow links from head, filling order
	function automatic int walk_chain();
		int n = 0;
		logic [5:0] s = head;
		for (int i = 0; i < slle_pkg::SLOTS; i++) seen[i] = 0;
		while (s != 0 && !seen[s] && n < slle_pkg::SLOTS - 1) begin
			seen[s] = 1;
			order[n++] = s;
			s = nxt[s];
		end
		return n;
	endfunction

	function automatic logic [5:0] lowest_free();
		for (int s = 1; s < slle_pkg::SLOTS; s++)
			if (nxt[s] == 0 && s != tail) return 6'(s);
		return 6'd0;
	endfunction

	// apply one request to the list copy and return the expected reply
	function automatic reply_t apply_list_op(logic [3:0] cmd, logic [31:0] val,
			logic [5:0] pos);
		reply_t r;
		int n;
		bit pos_ok;
		logic [5:0] s, p, q;
		longint sum, mag, quo;
		r = '0;
		n = walk_chain();
		pos_ok = pos != 0 && seen[pos];
		if (cmd <= slle_pkg::CMD_INS_AFTER) begin
			s = lowest_free();
			if (cmd == slle_pkg::CMD_INS_AFTER && !pos_ok) r.status = slle_pkg::ST_BADPOS;
			else if (n >= slle_pkg::SLOTS - 1 || s == 0) r.status = slle_pkg::ST_FULL;
			else begin
				vals[s] = val;
				if (cmd == slle_pkg::CMD_INS_AFTER) begin
					nxt[s] = nxt[pos];
					nxt[pos] = s;
					if (tail == pos) tail = s;
				end else if (n == 0) begin
					nxt[s] = 0; head = s; tail = s;
				end else if (cmd == slle_pkg::CMD_INS_FRONT) begin
					nxt[s] = head; head = s;
				end else begin
					nxt[tail] = s; nxt[s] = 0; tail = s;
				end
				r.slot = s;
				n++;
			end
		end else if (cmd == slle_pkg::CMD_DEL_AFTER) begin
			q = pos_ok ? nxt[pos] : 6'd0;
			if (!pos_ok || q == 0) r.status = slle_pkg::ST_BADPOS;
			else begin
				nxt[pos] = nxt[q];
				nxt[q] = 0;
				if (tail == q) tail = pos;
				r.slot = q;
				n--;
			end
		end else if (cmd > slle_pkg::CMD_COUNT) begin
			r.status = slle_pkg::ST_BADPOS;
		end else if (cmd == slle_pkg::CMD_COUNT) begin
			// count only
		end else if (n == 0) begin
			r.status = slle_pkg::ST_EMPTY;
		end else begin
			unique case (cmd)
				slle_pkg::CMD_DEL_FRONT: begin
					s = head;
					head = nxt[s];
					nxt[s] = 0;
					if (head == 0) tail = 0;
					r.slot = s;
					n--;
				end
				slle_pkg::CMD_DEL_BACK: begin
					s = order[n-1];
					nxt[s] = 0;
					if (n == 1) begin
						head = 0; tail = 0;
					end else begin
						p = order[n-2];
						nxt[p] = 0;
						tail = p;
					end
					r.slot = s;
					n--;
				end
				slle_pkg::CMD_REVERSE: begin
					nxt[order[0]] = 0;
					for (int k = 1; k < n; k++) nxt[order[k]] = order[k-1];
					head = order[n-1];
					tail = order[0];
					r.slot = head;
				end
				slle_pkg::CMD_SEARCH: begin
					r.status = slle_pkg::ST_EMPTY;
					for (int k = 0; k < n; k++)
						if (vals[order[k]] == val) begin
							r.slot = order[k];
							r.status = slle_pkg::ST_OK;
							break;
						end
				end
				slle_pkg::CMD_MIN: begin
					s = order[0];
					for (int k = 1; k < n; k++)
						if ($signed(vals[order[k]]) < $signed(vals[s])) s = order[k];
					r.slot = s;
					r.data = vals[s];
				end
				default: begin
					sum = 0;
					for (int k = 0; k < n; k++) sum += longint'($signed(vals[order[k]]));
					mag = sum < 0 ? -sum : sum;
					quo = mag / n;
					if (sum < 0) quo = -quo;
					r.data = quo[31:0];
				end
			endcase
		end
		r.count = n[5:0];
		return r;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#400ms;
		$display("Regression FAIL");
		$finish;
	end

	// result checker
	always @(posedge clk) begin
		reply_t got, want;
		if (arst_n && done) begin
			got = '{status, slot, data, count};
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply %h", $time, got);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status)
					$display("%0t: status exp %0d act %0d", $time, want.status, got.status);
				if (got.slot !== want.slot)
					$display("%0t: slot exp %0d act %0d", $time, want.slot, got.slot);
				if (got.data !== want.data)
					$display("%0t: data exp %h act %h", $time, want.data, got.data);
				if (got.count !== want.count)
					$display("%0t: count exp %0d act %0d", $time, want.count, got.count);
				if (got !== want) errors++;
			end
		end
	end

	// issue one request; row expectation optional
	task automatic send_request(logic [3:0] cmd, logic [31:0] val, logic [5:0] pos,
			bit has_exp, reply_t exp);
		reply_t r;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		command <= cmd;
		value <= val;
		position <= pos;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = apply_list_op(cmd, val, pos);
		if (has_exp && r !== exp) begin
			$display("%0t: table row exp %h, predictor %h", $time, exp, r);
			errors++;
		end
		pending_replies.push_back(has_exp ? exp : r);
		start <= 0;
		@(posedge clk);
	endtask

	function automatic logic [5:0] pick_pos();
		int n = walk_chain();
		if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom);
		return order[$urandom_range(0, n - 1)];
	endfunction

	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	row_t rows[$];

	function automatic row_t mk(logic [3:0] c, logic [31:0] v, logic [5:0] p,
			bit h, reply_t e);
		row_t r;
		r.cmd = c; r.val = v; r.pos = p; r.has_exp = h; r.exp = e;
		return r;
	endfunction

	initial begin
		int n, mode, wait_cnt;
		logic [3:0] c;
		start = 0; command = 0; value = 0; position = 0;
		arst_n = 0;
		for (int i = 0; i < slle_pkg::SLOTS; i++) begin
			nxt[i] = 0; vals[i] = 0;
		end
		head = 0; tail = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty list cases, extremes, every command
		rows.push_back(mk(slle_pkg::CMD_COUNT, 0, 0, 1, '{slle_pkg::ST_OK, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_DEL_FRONT, 0, 0, 1, '{slle_pkg::ST_EMPTY, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_DEL_BACK, 0, 0, 1, '{slle_pkg::ST_EMPTY, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_REVERSE, 0, 0, 1, '{slle_pkg::ST_EMPTY, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_SEARCH, 0, 0, 1, '{slle_pkg::ST_EMPTY, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_MIN, 0, 0, 1, '{slle_pkg::ST_EMPTY, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_AVG, 0, 0, 1, '{slle_pkg::ST_EMPTY, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_INS_AFTER, 5, 1, 1, '{slle_pkg::ST_BADPOS, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_DEL_AFTER, 0, 0, 1, '{slle_pkg::ST_BADPOS, 0, 0, 0}));
		rows.push_back(mk(4'd15, 0, 63, 1, '{slle_pkg::ST_BADPOS, 0, 0, 0}));
		rows.push_back(mk(slle_pkg::CMD_INS_BACK, 32'h8000_0000, 0, 1,
			'{slle_pkg::ST_OK, 1, 0, 1}));
		rows.push_back(mk(slle_pkg::CMD_REVERSE, 0, 0, 1, '{slle_pkg::ST_OK, 1, 0, 1}));
		rows.push_back(mk(slle_pkg::CMD_DEL_AFTER, 0, 1, 1, '{slle_pkg::ST_BADPOS, 0, 0, 1}));
		rows.push_back(mk(slle_pkg::CMD_INS_FRONT, 32'h7fff_ffff, 0, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_INS_AFTER, 32'hffff_ffff, 63, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_INS_AFTER, 32'h0000_0001, 1, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_SEARCH, 32'h8000_0000, 0, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_MIN, 0, 0, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_AVG, 0, 0, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_REVERSE, 0, 0, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_DEL_AFTER, 0, 2, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_DEL_BACK, 0, 0, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_DEL_FRONT, 0, 0, 0, '0));
		rows.push_back(mk(slle_pkg::CMD_DEL_FRONT, 0, 0, 0, '0));
		rows.push_back(mk(4'd11, 32'h5555_aaaa, 42, 0, '0));
		foreach (rows[i])
			send_request(rows[i].cmd, rows[i].val, rows[i].pos, rows[i].has_exp, rows[i].exp);

		// hold off until every reply is in
		wait_cnt = 0;
		while (pending_replies.size() != 0 && wait_cnt < 10000) begin
			@(posedge clk); wait_cnt++;
		end

		// random: phases lean toward filling, draining or mixing
		for (int i = 0; i < 1450; i++) begin
			if (i % 150 == 0) mode = $urandom_range(0, 2);
			if (i > 1300) quiet = 1;
			n = walk_chain();
			if ($urandom_range(0, 19) == 0) c = 4'($urandom);
			else if (mode == 0 && $urandom_range(0, 2) != 0) c = 4'($urandom_range(0, 2));
			else if (mode == 1 && $urandom_range(0, 2) != 0) c = 4'($urandom_range(3, 5));
			else c = 4'($urandom_range(0, 10));
			send_request(c, (c == slle_pkg::CMD_SEARCH && n > 0 && $urandom_range(0, 1)) ?
				vals[order[$urandom_range(0, n - 1)]] : pick_val(), pick_pos(), 0, '0);
		end

		wait_cnt = 0;
		while (pending_replies.size() != 0 && wait_cnt < 10000) begin
			@(posedge clk); wait_cnt++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_replies.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[files.f]
design/slle_pkg.sv
design/slle_store.sv
design/slle_div.sv
design/static_linked_list_engine.sv
verif/static_linked_list_engine_test.sv
